[design/srr_pkg.sv]
// shared types and constants for the sequenced reorder release block
// no dependencies; imported by every module of the block except srr_ram
`default_nettype none

package srr_pkg;

  // ring of buffer slots, indexed by message number modulo the ring size
  localparam int SRR_WINDOW   = 32;
  localparam int SRR_WIN_BITS = $clog2(SRR_WINDOW);

  // depth of the command queue between front and back
  localparam int SRR_QDEPTH = 2;

  localparam int SRR_NUM_W    = 32;
  localparam int SRR_PERIOD_W = 16;

  // result kinds
  typedef enum logic [2:0] {
    KIND_IDLE     = 3'd0,
    KIND_RELEASE  = 3'd1,
    KIND_STALE    = 3'd2,
    KIND_WINDOW   = 3'd3,
    KIND_SESSION  = 3'd4,
    KIND_QUERY    = 3'd5
  } srr_kind_t;

  // input operation codes
  localparam logic OP_MESSAGE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // classified work handed from front to back
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_REJECT = 2'd1,
    CMD_STORE  = 2'd2
  } srr_cmd_op_t;

  typedef struct packed {
    srr_cmd_op_t           op;
    srr_kind_t             kind;
    logic [SRR_NUM_W-1:0]  number;
    logic [SRR_NUM_W-1:0]  payload;
    logic                  sig;
    logic                  first;
  } srr_cmd_t;

  // status returned from back to front
  typedef struct packed {
    logic                  done;
    logic [SRR_NUM_W-1:0]  next_expected;
  } srr_status_t;

endpackage

`default_nettype wire

[design/srr_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module srr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/srr_queue.sv]
// short command queue between the front classifier and the back executor
// depends on srr_pkg for the command type
`default_nettype none

module srr_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire srr_pkg::srr_cmd_t push_data,
  input  wire logic              pop,
  output srr_pkg::srr_cmd_t      pop_data,
  output logic                   empty
);

  import srr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  srr_cmd_t           entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               full;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign pop_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      priority if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

  // a transaction is never pushed into a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into full queue");

  // the back never pops an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command popped from empty queue");

endmodule

`default_nettype wire

[design/srr_front.sv]
// front: accepts transactions, tracks the session and classifies each item
// depends on srr_pkg; reads next_expected back from the executor status
`default_nettype none

module srr_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          operation,
  input  wire logic [srr_pkg::SRR_NUM_W-1:0] msg_number,
  input  wire logic [srr_pkg::SRR_NUM_W-1:0] session_id,
  input  wire logic                          signed_flag,
  input  wire logic [srr_pkg::SRR_NUM_W-1:0] payload_tag,
  input  wire srr_pkg::srr_status_t          status,
  output logic                               push,
  output srr_pkg::srr_cmd_t                  cmd
);

  import srr_pkg::*;

  logic                 started;
  logic [SRR_NUM_W-1:0] current_session;

  logic [SRR_NUM_W-1:0] eff_expected;
  logic [SRR_NUM_W-1:0] eff_session;
  logic [SRR_NUM_W-1:0] ahead;

  assign push = start && !busy;

  // classify against the session and the expected number
  always_comb begin
    eff_expected = started ? status.next_expected : msg_number;
    eff_session  = started ? current_session : session_id;
    ahead        = msg_number - eff_expected;

    cmd.number  = msg_number;
    cmd.payload = payload_tag;
    cmd.sig     = signed_flag;
    cmd.first   = !started;
    cmd.kind    = KIND_IDLE;
    priority if (operation == OP_TICK) begin
      cmd.op = CMD_TICK;
    end else if (session_id != eff_session) begin
      cmd.op   = CMD_REJECT;
      cmd.kind = KIND_SESSION;
    end else if (msg_number < eff_expected) begin
      cmd.op   = CMD_REJECT;
      cmd.kind = KIND_STALE;
    end else if (ahead >= SRR_NUM_W'(SRR_WINDOW)) begin
      cmd.op   = CMD_REJECT;
      cmd.kind = KIND_WINDOW;
    end else begin
      cmd.op = CMD_STORE;
    end
  end

  // busy spans one transaction until the back reports it done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      priority if (push) begin
        busy <= 1'b1;
      end else if (status.done) begin
        busy <= 1'b0;
      end
    end
  end

  // the first message fixes the session
  always_ff @(posedge clk) begin
    if (rst) begin
      started         <= 1'b0;
      current_session <= '0;
    end else if (push && operation == OP_MESSAGE && !started) begin
      started         <= 1'b1;
      current_session <= session_id;
    end
  end

  // busy only drops when the back has finished the transaction
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> $past(status.done))
    else $error("busy dropped without completion");

endmodule

`default_nettype wire

[design/srr_back.sv]
// back: executes classified commands, owns the slot ring, watermark and gap timer
// depends on srr_pkg and srr_ram for the slot payload store
`default_nettype none

module srr_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_empty,
  input  wire srr_pkg::srr_cmd_t                q_data,
  output logic                                  q_pop,
  output srr_pkg::srr_status_t                  status,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [srr_pkg::SRR_PERIOD_W-1:0] cfg_data,
  output logic                                  strobe,
  output logic      [2:0]                       kind,
  output logic      [srr_pkg::SRR_NUM_W-1:0]    out_number,
  output logic      [srr_pkg::SRR_NUM_W-1:0]    out_payload,
  output logic                                  last
);

  import srr_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_WRITE  = 6'b000100,
    ST_LOOK   = 6'b001000,
    ST_EMIT   = 6'b010000,
    ST_SETTLE = 6'b100000
  } state_t;

  state_t                  state;
  state_t                  state_next;
  srr_cmd_t                cur;

  logic [SRR_NUM_W-1:0]    next_expected;
  logic [SRR_NUM_W-1:0]    verified_mark;
  logic [SRR_NUM_W-1:0]    gap_number;
  logic                    timer_armed;
  logic [SRR_PERIOD_W-1:0] timer_count;
  logic [SRR_PERIOD_W-1:0] query_period;
  logic [SRR_WINDOW-1:0]   slot_valid;
  logic                    done;

  logic [SRR_NUM_W-1:0]    slot_data;
  logic                    ram_we;

  logic [SRR_WIN_BITS-1:0] head_idx;
  logic [SRR_NUM_W-1:0]    expected_inc;
  logic                    can_release;
  logic                    next_ok;
  logic [SRR_PERIOD_W-1:0] period_eff;
  logic [SRR_PERIOD_W-1:0] count_inc;
  logic                    any_buffered;

  assign cfg_ready            = 1'b1;
  assign status.next_expected = next_expected;
  assign status.done          = done;
  assign q_pop                = (state == ST_IDLE) && !q_empty;
  assign ram_we               = (state == ST_WRITE);

  // release checks at the head of the ring and one number ahead
  always_comb begin
    head_idx     = next_expected[SRR_WIN_BITS-1:0];
    expected_inc = next_expected + 1'b1;
    can_release  = slot_valid[head_idx] && (next_expected <= verified_mark);
    next_ok      = slot_valid[expected_inc[SRR_WIN_BITS-1:0]] &&
                   (expected_inc <= verified_mark);
    any_buffered = |slot_valid;
    period_eff   = (query_period == '0) ? SRR_PERIOD_W'(1) : query_period;
    count_inc    = timer_count + 1'b1;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = (q_data.op == CMD_STORE) ? ST_WRITE : ST_EXEC;
        end
      end
      ST_EXEC:   state_next = ST_IDLE;
      ST_WRITE:  state_next = ST_LOOK;
      ST_LOOK:   state_next = ST_EMIT;
      ST_EMIT:   state_next = (can_release && next_ok) ? ST_LOOK : ST_SETTLE;
      ST_SETTLE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // current command
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      query_period <= SRR_PERIOD_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      query_period <= cfg_data;
    end
  end

  // ordering state, timer and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      next_expected <= '0;
      verified_mark <= '0;
      gap_number    <= '0;
      timer_armed   <= 1'b0;
      timer_count   <= '0;
      slot_valid    <= '0;
      strobe        <= 1'b0;
      done          <= 1'b0;
    end else begin
      strobe <= 1'b0;
      done   <= 1'b0;
      unique case (state)
        ST_EXEC: begin
          strobe <= 1'b1;
          done   <= 1'b1;
          if (cur.op == CMD_TICK) begin
            if (timer_armed && count_inc >= period_eff) begin
              timer_count <= '0;
            end else if (timer_armed) begin
              timer_count <= count_inc;
            end
          end
        end
        ST_WRITE: begin
          slot_valid[cur.number[SRR_WIN_BITS-1:0]] <= 1'b1;
          if (cur.first) begin
            next_expected <= cur.number;
          end
          if (cur.sig && cur.number > verified_mark) begin
            verified_mark <= cur.number;
          end
        end
        ST_EMIT: begin
          strobe <= 1'b1;
          if (can_release) begin
            slot_valid[head_idx] <= 1'b0;
            next_expected        <= expected_inc;
          end
        end
        ST_SETTLE: begin
          done <= 1'b1;
          priority if (!slot_valid[head_idx] && any_buffered &&
                       gap_number != next_expected) begin
            gap_number  <= next_expected;
            timer_armed <= 1'b1;
            timer_count <= '0;
          end else if (next_expected > gap_number) begin
            timer_armed <= 1'b0;
          end
        end
        ST_IDLE, ST_LOOK: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    unique case (state)
      ST_EXEC: begin
        last        <= 1'b1;
        out_payload <= '0;
        if (cur.op == CMD_TICK) begin
          if (timer_armed && count_inc >= period_eff) begin
            kind       <= KIND_QUERY;
            out_number <= gap_number;
          end else begin
            kind       <= KIND_IDLE;
            out_number <= '0;
          end
        end else begin
          kind       <= cur.kind;
          out_number <= cur.number;
        end
      end
      ST_EMIT: begin
        if (can_release) begin
          kind        <= KIND_RELEASE;
          out_number  <= next_expected;
          out_payload <= slot_data;
          last        <= !next_ok;
        end else begin
          kind        <= KIND_IDLE;
          out_number  <= '0;
          out_payload <= '0;
          last        <= 1'b1;
        end
      end
      ST_IDLE, ST_WRITE, ST_LOOK, ST_SETTLE: begin
      end
      default: begin
      end
    endcase
  end

  // slot payload store
  srr_ram #(
    .WIDTH (SRR_NUM_W),
    .DEPTH (SRR_WINDOW)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur.number[SRR_WIN_BITS-1:0]),
    .wdata (cur.payload),
    .raddr (head_idx),
    .rdata (slot_data)
  );

  // a result only comes out of an execute or emit step
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == ST_EXEC || state == ST_EMIT))
    else $error("result strobe outside execute or emit");

  // the expected number only moves on a store or a release
  assert property (@(posedge clk) disable iff (rst)
    !$stable(next_expected) |-> $past(state == ST_WRITE || state == ST_EMIT))
    else $error("next expected number moved unexpectedly");

endmodule

`default_nettype wire

[design/sequenced_reorder_release.sv]
// Sequenced reorder release. Raise start for one cycle with the item on the
// input ports while busy is low; busy stays high until the item is finished.
// Every result appears on kind/out_number/out_payload/last for exactly one
// cycle with strobe high and must be taken then; last marks the final result
// of an item. A tick or a rejected message passes through the execute state
// only. A buffered message is written to the slot ram, then loops through the
// look and emit states once per released message, or once with an idle result
// when it releases nothing, and then settles; each release is one read of the
// slot ram with its registered output. query_period may be written through
// cfg_valid/cfg_data whenever busy is low.
// depends on srr_pkg, srr_front, srr_queue, srr_back, srr_ram
`default_nettype none

module sequenced_reorder_release #(
  parameter int QUEUE_DEPTH = srr_pkg::SRR_QDEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             operation,
  input  wire logic [srr_pkg::SRR_NUM_W-1:0]    msg_number,
  input  wire logic [srr_pkg::SRR_NUM_W-1:0]    session_id,
  input  wire logic                             signed_flag,
  input  wire logic [srr_pkg::SRR_NUM_W-1:0]    payload_tag,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [srr_pkg::SRR_PERIOD_W-1:0] cfg_data,
  output logic                                  strobe,
  output logic      [2:0]                       kind,
  output logic      [srr_pkg::SRR_NUM_W-1:0]    out_number,
  output logic      [srr_pkg::SRR_NUM_W-1:0]    out_payload,
  output logic                                  last
);

  import srr_pkg::*;

  srr_cmd_t    cmd;
  srr_cmd_t    q_data;
  srr_status_t status;
  logic        push;
  logic        q_pop;
  logic        q_empty;

  // classification
  srr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .msg_number  (msg_number),
    .session_id  (session_id),
    .signed_flag (signed_flag),
    .payload_tag (payload_tag),
    .status      (status),
    .push        (push),
    .cmd         (cmd)
  );

  // command queue
  srr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // execution
  srr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .kind        (kind),
    .out_number  (out_number),
    .out_payload (out_payload),
    .last        (last)
  );

endmodule

`default_nettype wire
